// ===== rtl/core/tpd_pkg.sv =====
// Shared types, constants and widths of the tile packer and dictionary.
package tpd_pkg;

	// Dictionary and tile geometry.
	localparam int DICT_DEPTH  = 256;
	localparam int TILE_ROWS   = 8;
	localparam int TILE_BYTES  = 2 * TILE_ROWS;
	localparam int TILE_BITS   = 8 * TILE_BYTES;
	localparam int ROW_BITS    = 16;
	localparam int IDX_W       = $clog2(DICT_DEPTH);
	localparam int CNT_W       = $clog2(DICT_DEPTH + 1);
	localparam int CMP_W       = (CNT_W > 9) ? CNT_W : 9;
	localparam int ROW_CNT_W   = $clog2(TILE_ROWS);
	localparam int MM_W        = $clog2(TILE_BYTES + 1);

	// Command queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// Port field widths.
	localparam int REQ_W          = 2;
	localparam int ENTRY_W        = 8;
	localparam int OFFSET_W       = 4;
	localparam int TILE_ID_W      = 8;
	localparam int MISMATCH_W     = 8;
	localparam int ENTRY_COUNT_W  = 9;
	localparam int DATA_W         = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 9;
	localparam int MAX_TILES_W    = 9;
	localparam int ACC_ERR_W      = 5;

	// Request type codes on the input channel.
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ROW   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PACK_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TILES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACC_ERROR   = 2'd2;

	// Configuration reset values.
	localparam logic                   RST_PACK_ENABLE = 1'b1;
	localparam logic [MAX_TILES_W-1:0] RST_MAX_TILES   = 9'd255;
	localparam logic [ACC_ERR_W-1:0]   RST_ACC_ERROR   = 5'd0;

	// Best mismatch value reported when nothing was searched.
	localparam logic [MISMATCH_W-1:0] NO_SEARCH = 8'd255;

	typedef logic [CMP_W-1:0]         tpd_cmp_t;
	typedef logic [CNT_W-1:0]         tpd_cnt_t;
	typedef logic [IDX_W-1:0]         tpd_idx_t;
	typedef logic [MM_W-1:0]          tpd_mmc_t;
	typedef logic [MISMATCH_W-1:0]    tpd_mm_t;
	typedef logic [TILE_ID_W-1:0]     tpd_id_t;
	typedef logic [ENTRY_COUNT_W-1:0] tpd_ecnt_t;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_TILE  = 2'd1,
		CMD_READ  = 2'd2
	} tpd_cmd_kind_t;

	// One queued command for the back part.
	typedef struct packed {
		tpd_cmd_kind_t          kind;
		logic [TILE_BITS-1:0]   tile;
		logic [ENTRY_W-1:0]     rd_entry;
		logic [OFFSET_W-1:0]    rd_offset;
	} tpd_cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic empty;
		logic full;
	} tpd_qstat_t;

	// Configuration register set.
	typedef struct packed {
		logic                   pack_enable;
		logic [MAX_TILES_W-1:0] max_tiles;
		logic [ACC_ERR_W-1:0]   match_tol;
	} tpd_cfg_t;

endpackage

// ===== rtl/core/tpd_front.sv =====
// Front part: takes requests, packs pixel rows into bit planes and queues commands.
module tpd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tpd_pkg::REQ_W-1:0]         req_type,
	input  logic [tpd_pkg::ROW_BITS-1:0]      row_pixels,
	input  logic [tpd_pkg::ENTRY_W-1:0]       read_entry,
	input  logic [tpd_pkg::OFFSET_W-1:0]      read_offset,
	input  tpd_pkg::tpd_qstat_t               qstat,
	output logic                              push,
	output tpd_pkg::tpd_cmd_t                 push_cmd
);

	logic [tpd_pkg::TILE_BITS-1:0]  tile_q;
	logic [tpd_pkg::ROW_CNT_W-1:0]  row_cnt_q;
	logic [tpd_pkg::TILE_BITS-1:0]  tile_next;
	logic [7:0]                     plane0;
	logic [7:0]                     plane1;
	logic                           last_row;
	logic                           needs_push;
	logic                           accept;

	// Split the row into its low and high bit planes, pixel 0 in bit 7.
	always_comb begin
		for (int p = 0; p < 8; p++) begin
			plane0[7 - p] = row_pixels[14 - 2 * p];
			plane1[7 - p] = row_pixels[15 - 2 * p];
		end
	end

	// Tile with the current row inserted.
	always_comb begin
		tile_next = tile_q;
		tile_next[{row_cnt_q, 4'b0000} +: 16] = {plane1, plane0};
	end

	assign last_row   = (row_cnt_q == tpd_pkg::ROW_CNT_W'(tpd_pkg::TILE_ROWS - 1));
	assign needs_push = (req_type == tpd_pkg::REQ_CLEAR) || (req_type == tpd_pkg::REQ_READ)
		|| ((req_type == tpd_pkg::REQ_ROW) && last_row);
	assign in_stall   = needs_push && qstat.full;
	assign accept     = in_valid && !in_stall;
	assign push       = accept && needs_push;

	// Build the queued command from the request.
	always_comb begin
		push_cmd.tile      = tile_next;
		push_cmd.rd_entry  = read_entry;
		push_cmd.rd_offset = read_offset;
		if (req_type == tpd_pkg::REQ_CLEAR) begin
			push_cmd.kind = tpd_pkg::CMD_CLEAR;
		end else if (req_type == tpd_pkg::REQ_READ) begin
			push_cmd.kind = tpd_pkg::CMD_READ;
		end else begin
			push_cmd.kind = tpd_pkg::CMD_TILE;
		end
	end

	// Row counter advances on each accepted row; wraps after the last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
		end else if (accept && (req_type == tpd_pkg::REQ_ROW)) begin
			if (last_row) begin
				row_cnt_q <= '0;
			end else begin
				row_cnt_q <= row_cnt_q + 1'b1;
			end
		end
	end

	// Row collection buffer; every row is written before the tile is used.
	always_ff @(posedge clk) begin
		if (accept && (req_type == tpd_pkg::REQ_ROW)) begin
			tile_q <= tile_next;
		end
	end

endmodule

// ===== rtl/core/tpd_queue.sv =====
// Short command queue between the front and back parts.
module tpd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tpd_pkg::tpd_cmd_t    push_cmd,
	input  logic                 pop,
	output tpd_pkg::tpd_cmd_t    head,
	output tpd_pkg::tpd_qstat_t  qstat
);

	tpd_pkg::tpd_cmd_t               slot_q [tpd_pkg::QUEUE_DEPTH];
	logic [tpd_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [tpd_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [tpd_pkg::Q_CNT_W-1:0]     cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == tpd_pkg::Q_CNT_W'(tpd_pkg::QUEUE_DEPTH));
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == tpd_pkg::Q_PTR_W'(tpd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tpd_pkg::Q_PTR_W'(tpd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/core/tpd_back.sv =====
// Back part: dictionary memory, search, append, read replies and result register.
module tpd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tpd_pkg::tpd_cfg_t                   cfg,
	input  tpd_pkg::tpd_cmd_t                   head,
	input  tpd_pkg::tpd_qstat_t                 qstat,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tpd_pkg::TILE_ID_W-1:0]       tile_id,
	output logic                                is_new,
	output logic                                overflowed,
	output logic [tpd_pkg::MISMATCH_W-1:0]      best_mismatch,
	output logic [tpd_pkg::ENTRY_COUNT_W-1:0]   entry_count,
	output logic [tpd_pkg::DATA_W-1:0]          read_data,
	output logic                                is_read_reply
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RD     = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_DECIDE = 4'b1000
	} tpd_bstate_t;

	tpd_bstate_t                     state_q;
	logic [tpd_pkg::TILE_BITS-1:0]   dict_mem [tpd_pkg::DICT_DEPTH];
	logic [tpd_pkg::TILE_BITS-1:0]   mem_rdata_q;
	logic [tpd_pkg::TILE_BITS-1:0]   tile_q;
	tpd_pkg::tpd_cnt_t               count_q;
	tpd_pkg::tpd_cnt_t               scan_addr_q;
	tpd_pkg::tpd_mm_t                best_q;
	tpd_pkg::tpd_idx_t               best_id_q;
	logic                            rd_hit_q;
	logic [tpd_pkg::OFFSET_W-1:0]    rd_offset_q;

	// Scan pipeline: read data stage and mismatch count stage.
	logic                            v_s1;
	tpd_pkg::tpd_idx_t               idx_s1;
	logic                            v_s2;
	tpd_pkg::tpd_idx_t               idx_s2;
	tpd_pkg::tpd_mmc_t               mm_s2;

	// Result register.
	logic                            out_valid_q;
	tpd_pkg::tpd_id_t                tile_id_q;
	logic                            is_new_q;
	logic                            overflowed_q;
	tpd_pkg::tpd_mm_t                best_mismatch_q;
	tpd_pkg::tpd_ecnt_t              entry_count_q;
	logic [tpd_pkg::DATA_W-1:0]      read_data_q;
	logic                            is_read_reply_q;

	logic                            out_free;
	logic                            load;
	logic                            issue;
	logic                            scan_done;
	logic                            rd_hit;
	logic                            mem_re;
	tpd_pkg::tpd_idx_t               mem_raddr;
	logic                            mem_we;
	tpd_pkg::tpd_cmp_t               limit;
	logic                            full;
	logic                            match;
	logic                            append;
	logic [tpd_pkg::TILE_BYTES-1:0]  byte_diff;

	// Decision for a finished tile search.
	always_comb begin
		if (tpd_pkg::tpd_cmp_t'(cfg.max_tiles) > tpd_pkg::tpd_cmp_t'(tpd_pkg::DICT_DEPTH)) begin
			limit = tpd_pkg::tpd_cmp_t'(tpd_pkg::DICT_DEPTH);
		end else begin
			limit = tpd_pkg::tpd_cmp_t'(cfg.max_tiles);
		end
		full   = tpd_pkg::tpd_cmp_t'(count_q) >= limit;
		match  = cfg.pack_enable && (best_q <= tpd_pkg::tpd_mm_t'(cfg.match_tol));
		append = !match && !full;
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign load      = ((state_q == ST_RD) || (state_q == ST_DECIDE)) && out_free;
	assign pop       = (state_q == ST_IDLE) && !qstat.empty;
	assign rd_hit    = tpd_pkg::tpd_cmp_t'(head.rd_entry) < tpd_pkg::tpd_cmp_t'(count_q);
	assign issue     = (state_q == ST_SCAN) && (scan_addr_q < count_q);
	assign scan_done = (state_q == ST_SCAN) && !issue && !v_s1 && !v_s2;
	assign mem_we    = (state_q == ST_DECIDE) && out_free && append;

	// Single read port, shared by read requests and the search.
	always_comb begin
		if (state_q == ST_SCAN) begin
			mem_re    = issue;
			mem_raddr = tpd_pkg::tpd_idx_t'(scan_addr_q);
		end else begin
			mem_re    = pop && (head.kind == tpd_pkg::CMD_READ) && rd_hit;
			mem_raddr = tpd_pkg::tpd_idx_t'(head.rd_entry);
		end
	end

	// Dictionary memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dict_mem[tpd_pkg::tpd_idx_t'(count_q)] <= tile_q;
		end
		if (mem_re) begin
			mem_rdata_q <= dict_mem[mem_raddr];
		end
	end

	// Per-byte compare of a stored entry against the tile.
	always_comb begin
		for (int j = 0; j < tpd_pkg::TILE_BYTES; j++) begin
			byte_diff[j] = (mem_rdata_q[8 * j +: 8] != tile_q[8 * j +: 8]);
		end
	end

	// Control state: sequencer, entry count, scan valids and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.kind)
							tpd_pkg::CMD_CLEAR: count_q <= '0;
							tpd_pkg::CMD_READ:  state_q <= ST_RD;
							default: begin
								if (cfg.pack_enable && (count_q != '0)) begin
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_DECIDE;
								end
							end
						endcase
					end
				end
				ST_RD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command operands, scan address and running best match.
	always_ff @(posedge clk) begin
		if (pop) begin
			tile_q      <= head.tile;
			rd_hit_q    <= rd_hit;
			rd_offset_q <= head.rd_offset;
			scan_addr_q <= '0;
			best_q      <= tpd_pkg::NO_SEARCH;
			best_id_q   <= '0;
		end else begin
			if (issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (v_s2 && (tpd_pkg::tpd_mm_t'(mm_s2) < best_q)) begin
				best_q    <= tpd_pkg::tpd_mm_t'(mm_s2);
				best_id_q <= idx_s2;
			end
		end
		idx_s1 <= tpd_pkg::tpd_idx_t'(scan_addr_q);
		idx_s2 <= idx_s1;
		mm_s2  <= tpd_pkg::tpd_mmc_t'($countones(byte_diff));
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == ST_RD) begin
				tile_id_q       <= '0;
				is_new_q        <= 1'b0;
				overflowed_q    <= 1'b0;
				best_mismatch_q <= '0;
				entry_count_q   <= tpd_pkg::tpd_ecnt_t'(count_q);
				read_data_q     <= rd_hit_q ? mem_rdata_q[{rd_offset_q, 3'b000} +: 8] : '0;
				is_read_reply_q <= 1'b1;
			end else begin
				tile_id_q       <= append ? tpd_pkg::tpd_id_t'(count_q)
					: tpd_pkg::tpd_id_t'(best_id_q);
				is_new_q        <= append;
				overflowed_q    <= !match && full;
				best_mismatch_q <= best_q;
				entry_count_q   <= append ? tpd_pkg::tpd_ecnt_t'(count_q + 1'b1)
					: tpd_pkg::tpd_ecnt_t'(count_q);
				read_data_q     <= '0;
				is_read_reply_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign tile_id       = tile_id_q;
	assign is_new        = is_new_q;
	assign overflowed    = overflowed_q;
	assign best_mismatch = best_mismatch_q;
	assign entry_count   = entry_count_q;
	assign read_data     = read_data_q;
	assign is_read_reply = is_read_reply_q;

	// The entry count never passes the dictionary depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tpd_pkg::tpd_cmp_t'(count_q) <= tpd_pkg::tpd_cmp_t'(tpd_pkg::DICT_DEPTH))
		else $error("entry count beyond dictionary depth");

	// Search reads only come back while a search is running.
	a_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_SCAN))
		else $error("search data outside the search");

	// An append grows the dictionary by exactly one entry.
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (count_q == $past(count_q) + 1'b1))
		else $error("append did not advance the entry count");

	// A newly appended tile never reports an empty dictionary.
	a_new_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_new_q) |-> (entry_count_q != '0))
		else $error("new tile with an empty dictionary");

endmodule

// ===== rtl/core/tile_pack_and_dedup.sv =====
// Top level of the planar tile packer with dictionary deduplication.
// Each row request is taken by the front part, which packs the row into two
// bit-plane bytes. A clear, a read, or the eighth row of a tile becomes a
// command in a two-entry queue; the back part carries commands out in order.
// A completed tile is compared with the stored entries one entry per cycle
// through the single read port of the dictionary memory; with packing off or
// an empty dictionary no search is made. A stalled result holds the back part
// until it leaves. The dictionary needs no clearing pass.
module tile_pack_and_dedup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tpd_pkg::REQ_W-1:0]           req_type,
	input  logic [tpd_pkg::ROW_BITS-1:0]        row_pixels,
	input  logic [tpd_pkg::ENTRY_W-1:0]         read_entry,
	input  logic [tpd_pkg::OFFSET_W-1:0]        read_offset,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tpd_pkg::TILE_ID_W-1:0]       tile_id,
	output logic                                is_new,
	output logic                                overflowed,
	output logic [tpd_pkg::MISMATCH_W-1:0]      best_mismatch,
	output logic [tpd_pkg::ENTRY_COUNT_W-1:0]   entry_count,
	output logic [tpd_pkg::DATA_W-1:0]          read_data,
	output logic                                is_read_reply,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	tpd_pkg::tpd_cfg_t    cfg_q;
	tpd_pkg::tpd_qstat_t  qstat;
	tpd_pkg::tpd_cmd_t    push_cmd;
	tpd_pkg::tpd_cmd_t    head;
	logic                 push;
	logic                 pop;

	assign cfg_ready = 1'b1;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pack_enable <= tpd_pkg::RST_PACK_ENABLE;
			cfg_q.max_tiles   <= tpd_pkg::RST_MAX_TILES;
			cfg_q.match_tol   <= tpd_pkg::RST_ACC_ERROR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tpd_pkg::CFG_PACK_ENABLE: cfg_q.pack_enable <= cfg_data[0];
				tpd_pkg::CFG_MAX_TILES:   cfg_q.max_tiles   <= cfg_data;
				tpd_pkg::CFG_ACC_ERROR:   cfg_q.match_tol   <=
					cfg_data[tpd_pkg::ACC_ERR_W-1:0];
				default: ;
			endcase
		end
	end

	tpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.row_pixels  (row_pixels),
		.read_entry  (read_entry),
		.read_offset (read_offset),
		.qstat       (qstat),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	tpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	tpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tile_id       (tile_id),
		.is_new        (is_new),
		.overflowed    (overflowed),
		.best_mismatch (best_mismatch),
		.entry_count   (entry_count),
		.read_data     (read_data),
		.is_read_reply (is_read_reply)
	);

endmodule
